// File: rtl/hrbm_pkg.sv
// Shared types, constants and the popcount function of the Hamming best-match block.
`default_nettype none

package hrbm_pkg;

	localparam int DESC_W   = 256;
	localparam int WORD_W   = 64;
	localparam int DIST_W   = 9;
	localparam int INDEX_W  = 10;
	localparam int LEVEL_W  = 3;
	localparam int LVLC_W   = 4;
	localparam int THRESH_W = 8;
	localparam int RATIO_W  = 9;
	localparam int ADDR_W   = 3;
	localparam int DATA_W   = 32;

	localparam logic [DIST_W-1:0]   DIST_NONE    = 9'd256;
	localparam logic [LVLC_W-1:0]   LVL_NONE     = 4'd15;
	localparam logic [THRESH_W-1:0] THRESH_RESET = 8'd100;
	localparam logic [RATIO_W-1:0]  RATIO_RESET  = 9'd154;

	typedef enum logic {
		REG_THRESHOLD = 1'b0,
		REG_RATIO     = 1'b1
	} reg_idx_t;

	typedef struct packed {
		logic [DIST_W-1:0]  distance;
		logic [LVLC_W-1:0]  lvl;
	} rank_t;

	function automatic logic [DIST_W-1:0] popcount256(input logic [DESC_W-1:0] v);
		logic [DIST_W-1:0] cnt [DESC_W];
		for (int i = 0; i < DESC_W; i++) begin
			cnt[i] = DIST_W'(v[i]);
		end
		// pairwise adder tree
		for (int w = DESC_W / 2; w > 0; w = w >> 1) begin
			for (int i = 0; i < w; i++) begin
				cnt[i] = cnt[2*i] + cnt[2*i+1];
			end
		end
		return cnt[0];
	endfunction

endpackage

`default_nettype wire

// File: rtl/hamming_ratio_best_match.sv
// Top level of the Hamming best-match block with nearest/second-nearest ratio test.
`default_nettype none

// One candidate request is taken every cycle unless the pipeline holds. A request
// passes an input register (descriptor XOR), a popcount register and then the
// running best/second-best update; a group's result enters the output register as
// its last request leaves the update stage. While a result waits at the output,
// the pipeline holds only when the next last request reaches the update stage.
// Registers: distance_threshold at byte address 0, ratio_q8 at byte address 4.
module hamming_ratio_best_match (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            psel,
	input  wire logic                            penable,
	input  wire logic                            pwrite,
	input  wire logic [hrbm_pkg::ADDR_W-1:0]     paddr,
	input  wire logic [hrbm_pkg::DATA_W-1:0]     pwdata,
	output logic      [hrbm_pkg::DATA_W-1:0]     prdata,
	output logic                                 pready,
	input  wire logic                            in_valid,
	output logic                                 in_ready,
	input  wire logic [hrbm_pkg::WORD_W-1:0]     query_word0,
	input  wire logic [hrbm_pkg::WORD_W-1:0]     query_word1,
	input  wire logic [hrbm_pkg::WORD_W-1:0]     query_word2,
	input  wire logic [hrbm_pkg::WORD_W-1:0]     query_word3,
	input  wire logic [hrbm_pkg::WORD_W-1:0]     cand_word0,
	input  wire logic [hrbm_pkg::WORD_W-1:0]     cand_word1,
	input  wire logic [hrbm_pkg::WORD_W-1:0]     cand_word2,
	input  wire logic [hrbm_pkg::WORD_W-1:0]     cand_word3,
	input  wire logic [hrbm_pkg::INDEX_W-1:0]    cand_index,
	input  wire logic [hrbm_pkg::LEVEL_W-1:0]    cand_level,
	input  wire logic                            cand_taken,
	input  wire logic                            group_last,
	output logic                                 out_valid,
	input  wire logic                            out_ready,
	output logic                                 matched,
	output logic      [hrbm_pkg::INDEX_W-1:0]    best_index,
	output logic      [hrbm_pkg::DIST_W-1:0]     best_distance,
	output logic      [hrbm_pkg::DIST_W-1:0]     second_distance
);

	logic [hrbm_pkg::THRESH_W-1:0] distance_threshold_q;
	logic [hrbm_pkg::RATIO_W-1:0]  ratio_q8_q;
	logic                          wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			distance_threshold_q <= hrbm_pkg::THRESH_RESET;
			ratio_q8_q           <= hrbm_pkg::RATIO_RESET;
		end else if (wr_en) begin
			case (hrbm_pkg::reg_idx_t'(paddr[2]))
				hrbm_pkg::REG_THRESHOLD: distance_threshold_q <= pwdata[hrbm_pkg::THRESH_W-1:0];
				hrbm_pkg::REG_RATIO:     ratio_q8_q           <= pwdata[hrbm_pkg::RATIO_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (hrbm_pkg::reg_idx_t'(paddr[2]))
			hrbm_pkg::REG_THRESHOLD: prdata = hrbm_pkg::DATA_W'(distance_threshold_q);
			hrbm_pkg::REG_RATIO:     prdata = hrbm_pkg::DATA_W'(ratio_q8_q);
			default:                 prdata = '0;
		endcase
	end

	// pipeline control
	logic v_s1, v_s2, out_valid_q;
	logic s2_stall, s2_fire, s1_move, in_fire;

	logic [hrbm_pkg::DESC_W-1:0]  diff_s1;
	logic [hrbm_pkg::INDEX_W-1:0] idx_s1, idx_s2;
	logic [hrbm_pkg::LEVEL_W-1:0] lvl_s1, lvl_s2;
	logic                         taken_s1, taken_s2, last_s1, last_s2;
	logic [hrbm_pkg::DIST_W-1:0]  dist_s2;

	assign s2_stall = v_s2 && last_s2 && out_valid_q && !out_ready;
	assign s2_fire  = v_s2 && !s2_stall;
	assign s1_move  = !s2_stall;
	assign in_ready = !v_s1 || s1_move;
	assign in_fire  = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (in_ready) begin
				v_s1 <= in_fire;
			end
			if (s1_move) begin
				v_s2 <= v_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			diff_s1  <= {query_word3 ^ cand_word3, query_word2 ^ cand_word2,
			             query_word1 ^ cand_word1, query_word0 ^ cand_word0};
			idx_s1   <= cand_index;
			lvl_s1   <= cand_level;
			taken_s1 <= cand_taken;
			last_s1  <= group_last;
		end
		if (s1_move && v_s1) begin
			dist_s2  <= hrbm_pkg::popcount256(diff_s1);
			idx_s2   <= idx_s1;
			lvl_s2   <= lvl_s1;
			taken_s2 <= taken_s1;
			last_s2  <= last_s1;
		end
	end

	// running best and second-best
	hrbm_pkg::rank_t              best_q, second_q, best_nx, second_nx;
	logic [hrbm_pkg::INDEX_W-1:0] best_idx_q, best_idx_nx;
	hrbm_pkg::rank_t              cand_rank;

	assign cand_rank = '{distance: dist_s2, lvl: hrbm_pkg::LVLC_W'(lvl_s2)};

	always_comb begin
		best_nx     = best_q;
		second_nx   = second_q;
		best_idx_nx = best_idx_q;
		if (!taken_s2) begin
			if (dist_s2 < best_q.distance) begin
				second_nx   = best_q;
				best_nx     = cand_rank;
				best_idx_nx = idx_s2;
			end else if (dist_s2 < second_q.distance) begin
				second_nx = cand_rank;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_q     <= '{distance: hrbm_pkg::DIST_NONE, lvl: hrbm_pkg::LVL_NONE};
			second_q   <= '{distance: hrbm_pkg::DIST_NONE, lvl: hrbm_pkg::LVL_NONE};
			best_idx_q <= '0;
		end else if (s2_fire) begin
			if (last_s2) begin
				best_q     <= '{distance: hrbm_pkg::DIST_NONE, lvl: hrbm_pkg::LVL_NONE};
				second_q   <= '{distance: hrbm_pkg::DIST_NONE, lvl: hrbm_pkg::LVL_NONE};
				best_idx_q <= '0;
			end else begin
				best_q     <= best_nx;
				second_q   <= second_nx;
				best_idx_q <= best_idx_nx;
			end
		end
	end

	// result register
	logic [hrbm_pkg::DIST_W-1:0]  res_best_q, res_second_q;
	logic [hrbm_pkg::INDEX_W-1:0] res_idx_q;
	logic                         res_same_lvl_q;
	logic                         res_load;

	assign res_load = s2_fire && last_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			res_best_q     <= best_nx.distance;
			res_second_q   <= second_nx.distance;
			res_idx_q      <= best_idx_nx;
			res_same_lvl_q <= best_nx.lvl == second_nx.lvl;
		end
	end

	logic [hrbm_pkg::DIST_W+hrbm_pkg::RATIO_W-1:0] lhs, rhs;
	logic                                          thresh_ok;

	assign lhs       = {res_best_q, 8'd0} + (hrbm_pkg::DIST_W+hrbm_pkg::RATIO_W)'(0);
	assign rhs       = (hrbm_pkg::DIST_W+hrbm_pkg::RATIO_W)'(ratio_q8_q) *
	                   (hrbm_pkg::DIST_W+hrbm_pkg::RATIO_W)'(res_second_q);
	assign thresh_ok = res_best_q <= hrbm_pkg::DIST_W'(distance_threshold_q);

	assign out_valid       = out_valid_q;
	assign matched         = thresh_ok && !(res_same_lvl_q && (lhs > rhs));
	assign best_index      = res_idx_q;
	assign best_distance   = res_best_q;
	assign second_distance = res_second_q;

`ifndef SYNTHESIS
	a_order: assert property (@(posedge clk) disable iff (!arst_n)
		best_q.distance <= second_q.distance)
		else $error("best distance above second-best");

	a_best_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(best_q.distance == hrbm_pkg::DIST_NONE) |->
		(best_idx_q == '0 && best_q.lvl == hrbm_pkg::LVL_NONE))
		else $error("empty best holds an index or level");

	a_second_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(second_q.distance == hrbm_pkg::DIST_NONE) |-> (second_q.lvl == hrbm_pkg::LVL_NONE))
		else $error("empty second-best holds a level");

	a_clear: assert property (@(posedge clk) disable iff (!arst_n)
		res_load |=> (best_q.distance == hrbm_pkg::DIST_NONE && out_valid_q))
		else $error("group end did not clear state or raise result");

	a_match: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && matched) |-> (res_best_q != hrbm_pkg::DIST_NONE))
		else $error("match reported with no counted candidate");
`endif

endmodule

`default_nettype wire

// File: tb/hamming_ratio_best_match_tb.sv
// Self-checking testbench for the Hamming best-match block with its ratio test.

typedef struct packed {
	bit [hrbm_pkg::DESC_W-1:0]  query;
	bit [hrbm_pkg::DESC_W-1:0]  cand;
	bit [hrbm_pkg::INDEX_W-1:0] idx;
	bit [hrbm_pkg::LEVEL_W-1:0] lvl;
	bit                         taken;
	bit                         last;
} cand_req_t;

typedef struct packed {
	bit                         matched;
	bit [hrbm_pkg::INDEX_W-1:0] index;
	bit [hrbm_pkg::DIST_W-1:0]  best;
	bit [hrbm_pkg::DIST_W-1:0]  second;
} match_result_t;

class match_scoreboard;
	bit [hrbm_pkg::THRESH_W-1:0] thresh;
	bit [hrbm_pkg::RATIO_W-1:0]  ratio;
	bit [hrbm_pkg::DIST_W-1:0]   best_d;
	bit [hrbm_pkg::DIST_W-1:0]   second_d;
	bit [hrbm_pkg::LVLC_W-1:0]   best_l;
	bit [hrbm_pkg::LVLC_W-1:0]   second_l;
	bit [hrbm_pkg::INDEX_W-1:0]  best_i;
	match_result_t               pending[$];
	int                          errors;

	function new();
		thresh = hrbm_pkg::THRESH_RESET;
		ratio  = hrbm_pkg::RATIO_RESET;
		errors = 0;
		clear_group();
	endfunction

	function void clear_group();
		best_d   = hrbm_pkg::DIST_NONE;
		second_d = hrbm_pkg::DIST_NONE;
		best_l   = hrbm_pkg::LVL_NONE;
		second_l = hrbm_pkg::LVL_NONE;
		best_i   = '0;
	endfunction

	function void note_request(cand_req_t r);
		int            d;
		bit            ok;
		match_result_t res;
		d = $countones(r.query ^ r.cand);
		if (!r.taken) begin
			if (d < int'(best_d)) begin
				second_d = best_d;
				second_l = best_l;
				best_d   = d[hrbm_pkg::DIST_W-1:0];
				best_l   = {1'b0, r.lvl};
				best_i   = r.idx;
			end else if (d < int'(second_d)) begin
				second_d = d[hrbm_pkg::DIST_W-1:0];
				second_l = {1'b0, r.lvl};
			end
		end
		if (r.last) begin
			ok = int'(best_d) <= int'(thresh);
			if (ok && best_l == second_l && int'(best_d) * 256 > int'(ratio) * int'(second_d))
				ok = 1'b0;
			res.matched = ok;
			res.index   = best_i;
			res.best    = best_d;
			res.second  = second_d;
			pending.push_back(res);
			clear_group();
		end
	endfunction

	function void check_result(match_result_t got);
		match_result_t exp_r;
		if (pending.size() == 0) begin
			$error("result with no request pending");
			errors++;
			return;
		end
		exp_r = pending.pop_front();
		if (got.matched != exp_r.matched) begin
			$error("matched: expected %0d, got %0d", exp_r.matched, got.matched);
			errors++;
		end
		if (got.index != exp_r.index) begin
			$error("best_index: expected %0d, got %0d", exp_r.index, got.index);
			errors++;
		end
		if (got.best != exp_r.best) begin
			$error("best_distance: expected %0d, got %0d", exp_r.best, got.best);
			errors++;
		end
		if (got.second != exp_r.second) begin
			$error("second_distance: expected %0d, got %0d", exp_r.second, got.second);
			errors++;
		end
	endfunction
endclass

module hamming_ratio_best_match_tb;
	timeunit 1ns;
	timeprecision 1ps;

	logic                          clk = 1'b0;
	logic                          arst_n = 1'b0;
	logic                          psel = 1'b0;
	logic                          penable = 1'b0;
	logic                          pwrite = 1'b0;
	logic [hrbm_pkg::ADDR_W-1:0]   paddr = '0;
	logic [hrbm_pkg::DATA_W-1:0]   pwdata = '0;
	logic [hrbm_pkg::DATA_W-1:0]   prdata;
	logic                          pready;
	logic                          in_valid = 1'b0;
	logic                          in_ready;
	logic [hrbm_pkg::WORD_W-1:0]   query_word0 = '0;
	logic [hrbm_pkg::WORD_W-1:0]   query_word1 = '0;
	logic [hrbm_pkg::WORD_W-1:0]   query_word2 = '0;
	logic [hrbm_pkg::WORD_W-1:0]   query_word3 = '0;
	logic [hrbm_pkg::WORD_W-1:0]   cand_word0 = '0;
	logic [hrbm_pkg::WORD_W-1:0]   cand_word1 = '0;
	logic [hrbm_pkg::WORD_W-1:0]   cand_word2 = '0;
	logic [hrbm_pkg::WORD_W-1:0]   cand_word3 = '0;
	logic [hrbm_pkg::INDEX_W-1:0]  cand_index = '0;
	logic [hrbm_pkg::LEVEL_W-1:0]  cand_level = '0;
	logic                          cand_taken = 1'b0;
	logic                          group_last = 1'b0;
	logic                          out_valid;
	logic                          out_ready = 1'b0;
	logic                          matched;
	logic [hrbm_pkg::INDEX_W-1:0]  best_index;
	logic [hrbm_pkg::DIST_W-1:0]   best_distance;
	logic [hrbm_pkg::DIST_W-1:0]   second_distance;

	match_scoreboard sb;
	int tx_idle_pct = 0;
	int rx_stall_pct = 0;
	int rx_hold = 0;

	hamming_ratio_best_match dut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.query_word0(query_word0),
		.query_word1(query_word1),
		.query_word2(query_word2),
		.query_word3(query_word3),
		.cand_word0(cand_word0),
		.cand_word1(cand_word1),
		.cand_word2(cand_word2),
		.cand_word3(cand_word3),
		.cand_index(cand_index),
		.cand_level(cand_level),
		.cand_taken(cand_taken),
		.group_last(group_last),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.matched(matched),
		.best_index(best_index),
		.best_distance(best_distance),
		.second_distance(second_distance)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	initial begin
		forever begin
			@(posedge clk);
			if (rx_hold > 0) begin
				out_ready <= 1'b0;
				rx_hold--;
			end else begin
				out_ready <= ($urandom_range(99) >= rx_stall_pct);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && in_valid && in_ready)
			sb.note_request(cand_req_t'{
				{query_word3, query_word2, query_word1, query_word0},
				{cand_word3, cand_word2, cand_word1, cand_word0},
				cand_index, cand_level, cand_taken, group_last});
		if (arst_n && out_valid && out_ready)
			sb.check_result(match_result_t'{matched, best_index, best_distance,
				second_distance});
	end

	initial begin
		#400000;
		$display("hamming_ratio_best_match_tb: done, errors");
		$finish;
	end

	function automatic bit [hrbm_pkg::DESC_W-1:0] rand_desc();
		bit [hrbm_pkg::DESC_W-1:0] v;
		for (int i = 0; i < hrbm_pkg::DESC_W / 32; i++)
			v[i*32 +: 32] = $urandom;
		return v;
	endfunction

	// exactly k ones, placed at a random rotation
	function automatic bit [hrbm_pkg::DESC_W-1:0] flip_mask(int k);
		bit [hrbm_pkg::DESC_W-1:0] m;
		int                        r;
		if (k <= 0)
			return '0;
		m = {hrbm_pkg::DESC_W{1'b1}} >> (hrbm_pkg::DESC_W - k);
		r = $urandom_range(hrbm_pkg::DESC_W - 1);
		return (m << r) | (m >> (hrbm_pkg::DESC_W - r));
	endfunction

	task automatic send_cand(input bit [hrbm_pkg::DESC_W-1:0] q,
			input bit [hrbm_pkg::DESC_W-1:0] c,
			input int idx, input int lvl, input bit taken, input bit last);
		if ($urandom_range(99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		{query_word3, query_word2, query_word1, query_word0} <= q;
		{cand_word3, cand_word2, cand_word1, cand_word0} <= c;
		cand_index <= idx[hrbm_pkg::INDEX_W-1:0];
		cand_level <= lvl[hrbm_pkg::LEVEL_W-1:0];
		cand_taken <= taken;
		group_last <= last;
		in_valid   <= 1'b1;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic write_reg(input hrbm_pkg::reg_idx_t r, input int value);
		logic [hrbm_pkg::DATA_W-1:0] want;
		want = (r == hrbm_pkg::REG_THRESHOLD) ? hrbm_pkg::DATA_W'(value & 8'hFF) :
		                                        hrbm_pkg::DATA_W'(value & 9'h1FF);
		@(posedge clk);
		psel    <= 1'b1;
		pwrite  <= 1'b1;
		penable <= 1'b0;
		paddr   <= hrbm_pkg::ADDR_W'(4 * int'(r));
		pwdata  <= want;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		pwrite  <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (prdata != want) begin
			$error("prdata: expected %0d, got %0d", want, prdata);
			sb.errors++;
		end
		psel    <= 1'b0;
		penable <= 1'b0;
		if (r == hrbm_pkg::REG_THRESHOLD)
			sb.thresh = want[hrbm_pkg::THRESH_W-1:0];
		else
			sb.ratio = want[hrbm_pkg::RATIO_W-1:0];
	endtask

	task automatic drain();
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	task automatic run_phase(input int tx, input int rx, input int thr, input int rat,
			input int items, input int max_len, input int hold);
		int                        sent;
		int                        len;
		int                        p;
		int                        k;
		int                        grp_lvl;
		bit [hrbm_pkg::DESC_W-1:0] q;
		bit [hrbm_pkg::DESC_W-1:0] c;
		drain();
		write_reg(hrbm_pkg::REG_THRESHOLD, thr);
		write_reg(hrbm_pkg::REG_RATIO, rat);
		tx_idle_pct  = tx;
		rx_stall_pct = rx;
		rx_hold      = hold;
		sent = 0;
		while (sent < items) begin
			p = $urandom_range(99);
			q = (p < 5) ? '0 : (p < 10) ? '1 : rand_desc();
			grp_lvl = $urandom_range(7);
			len = $urandom_range(1, max_len);
			for (int i = 0; i < len; i++) begin
				p = $urandom_range(99);
				if (p < 40)
					k = int'(sb.thresh) + $urandom_range(20) - 10;
				else if (p < 70)
					k = $urandom_range(hrbm_pkg::DESC_W);
				else if (p < 78)
					k = 0;
				else if (p < 84)
					k = hrbm_pkg::DESC_W;
				else
					k = -1;
				if (k > hrbm_pkg::DESC_W)
					k = hrbm_pkg::DESC_W;
				if (k < -1)
					k = 0;
				c = (k < 0) ? rand_desc() : q ^ flip_mask(k);
				send_cand(q, c, $urandom_range(1023),
					$urandom_range(1) ? grp_lvl : $urandom_range(7),
					$urandom_range(99) < 15, i == len - 1);
			end
			sent += len;
		end
		in_valid <= 1'b0;
	endtask

	initial begin
		bit [hrbm_pkg::DESC_W-1:0] q;
		sb = new();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_cand('0, '0, 1023, 7, 1'b0, 1'b1);
		send_cand('1, '0, 5, 0, 1'b0, 1'b1);
		q = rand_desc();
		send_cand(q, q, 7, 1, 1'b1, 1'b1);
		q = rand_desc();
		send_cand(q, q ^ flip_mask(50), 1, 3, 1'b0, 1'b0);
		send_cand(q, q ^ flip_mask(60), 2, 3, 1'b0, 1'b1);
		send_cand(q, q ^ flip_mask(30), 3, 4, 1'b0, 1'b0);
		send_cand(q, q ^ flip_mask(30), 4, 4, 1'b0, 1'b1);
		q = rand_desc();
		send_cand(q, q ^ flip_mask(40), 20, 2, 1'b0, 1'b0);
		send_cand(q, q ^ flip_mask(45), 21, 3, 1'b0, 1'b1);
		send_cand(q, q ^ flip_mask(100), 22, 1, 1'b0, 1'b1);
		send_cand(q, q ^ flip_mask(101), 23, 1, 1'b0, 1'b1);
		q = rand_desc();
		send_cand(q, q ^ flip_mask(80), 10, 5, 1'b0, 1'b0);
		send_cand(q, q ^ flip_mask(50), 11, 6, 1'b0, 1'b0);
		send_cand(q, q ^ flip_mask(60), 12, 5, 1'b0, 1'b0);
		send_cand(q, q, 13, 5, 1'b1, 1'b1);
		send_cand(q, q ^ flip_mask(10), 30, 2, 1'b0, 1'b0);
		send_cand(q, q ^ flip_mask(100), 31, 2, 1'b0, 1'b1);
		send_cand(q, q ^ flip_mask(77), 40, 0, 1'b0, 1'b0);
		send_cand(q, q ^ flip_mask(128), 41, 0, 1'b0, 1'b1);
		send_cand(q, q ^ flip_mask(78), 42, 0, 1'b0, 1'b0);
		send_cand(q, q ^ flip_mask(128), 43, 0, 1'b0, 1'b1);
		send_cand(q, q ^ flip_mask(256), 0, 7, 1'b0, 1'b1);
		in_valid <= 1'b0;

		run_phase(0, 0, 255, 256, 80, 6, 0);
		run_phase(47, 0, 0, 0, 80, 6, 0);
		run_phase(0, 47, 60, 200, 80, 6, 0);
		run_phase(6, 6, 128, 511, 80, 8, 0);
		run_phase(0, 0, 100, 154, 80, 2, 300);
		run_phase(47, 47, $urandom_range(255), $urandom_range(256), 80, 6, 0);
		drain();
		repeat (10) @(posedge clk);

		if (sb.errors == 0)
			$display("hamming_ratio_best_match_tb: done, clean");
		else
			$display("hamming_ratio_best_match_tb: done, errors");
		$finish;
	end

endmodule

// File: sim.f
rtl/hrbm_pkg.sv
rtl/hamming_ratio_best_match.sv
tb/hamming_ratio_best_match_tb.sv
